// ----- rtl/prb_pkg.sv -----
// Shared types and constants for the packet reorder buffer.
package prb_pkg;

    localparam int SEQ_W  = 16;
    localparam int DATA_W = 32;

    localparam logic [SEQ_W-1:0] FIRST_SEQ_RESET = 16'd1;

    typedef enum logic [1:0] {
        STATUS_RELEASED,
        STATUS_LATE,
        STATUS_BEYOND
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
    } chain_ctrl_t;

endpackage

// ----- rtl/packet_reorder_buffer.sv -----
// Packet reorder buffer: releases packets in sequence order from a shifting window of cells.
// Output timing: a drop status or an in-order release is loaded into the output register and
// appears on the master side in the cycle after the input transfer; a parked packet produces no result.
// Throughput: a run of n released packets (n <= WINDOW) leaves one per cycle while m_tready is high,
// set by the single output register; the next input is taken once the run is drained.
// Reset: expected sequence number is 1, all window cells empty, output register empty.
module packet_reorder_buffer
    import prb_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: first_sequence
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input packets
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] seq_number, [47:16] payload
    // released and dropped packets
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] out_payload, [47:32] out_seq
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_of_run
);

    localparam int IdxW  = $clog2(WINDOW);
    localparam int KeepW = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

    state_t            state_reg;
    state_t            state_next;
    logic [SEQ_W-1:0]  expected_reg;
    logic [SEQ_W-1:0]  expected_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_payload_reg;
    logic [DATA_W-1:0] out_payload_next;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [SEQ_W-1:0]  out_seq_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic              out_last_reg;
    logic              out_last_next;

    chain_ctrl_t       ctrl;
    logic [WINDOW-1:0] valid_vec;
    logic [KeepW-1:0]  head_payload;

    logic [SEQ_W-1:0]  in_seq;
    logic [DATA_W-1:0] in_payload;
    logic [SEQ_W-1:0]  delta;
    logic [IdxW-1:0]   delta_idx;
    logic              is_late;
    logic              is_beyond;
    logic              is_hit;
    logic              is_dup;
    logic              out_free;
    logic              in_fire;
    logic              cfg_fire;

    assign in_seq     = s_tdata[15:0];
    assign in_payload = s_tdata[47:16];
    assign delta      = in_seq - expected_reg;
    assign delta_idx  = delta[IdxW-1:0];
    assign is_late    = delta[SEQ_W-1];
    assign is_beyond  = !delta[SEQ_W-1] && (delta >= SEQ_W'(WINDOW));
    assign is_hit     = (delta == '0);
    assign is_dup     = valid_vec[delta_idx];

    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && out_free && !cfg_valid;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !is_late && !is_beyond && is_hit && valid_vec[1])
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free && !valid_vec[1])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // chain control, expected counter and output register
    always_comb
    begin
        ctrl             = '0;
        expected_next    = expected_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_payload_next = out_payload_reg;
        out_seq_next     = out_seq_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    ctrl.clear    = 1'b1;
                    expected_next = cfg_data;
                end
                else if (in_fire)
                begin
                    if (is_late || is_beyond || (!is_hit && is_dup))
                    begin
                        out_valid_next   = 1'b1;
                        out_payload_next = '0;
                        out_seq_next     = in_seq;
                        out_status_next  = is_beyond ? STATUS_BEYOND : STATUS_LATE;
                        out_last_next    = 1'b1;
                    end
                    else if (is_hit)
                    begin
                        // release now; the successor moves into the head cell
                        out_valid_next   = 1'b1;
                        out_payload_next = DATA_W'(in_payload[KeepW-1:0]);
                        out_seq_next     = in_seq;
                        out_status_next  = STATUS_RELEASED;
                        out_last_next    = !valid_vec[1];
                        ctrl.shift       = 1'b1;
                        expected_next    = expected_reg + 16'd1;
                    end
                    else
                    begin
                        ctrl.load = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_payload_next = DATA_W'(head_payload);
                    out_seq_next     = expected_reg;
                    out_status_next  = STATUS_RELEASED;
                    out_last_next    = !valid_vec[1];
                    ctrl.shift       = 1'b1;
                    expected_next    = expected_reg + 16'd1;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expected_reg  <= FIRST_SEQ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_payload_reg <= out_payload_next;
        out_seq_reg     <= out_seq_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    prb_chain #(
        .WINDOW(WINDOW),
        .KEEP_W(KeepW)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .load_idx    (delta_idx),
        .load_data   (in_payload[KeepW-1:0]),
        .valid_vec   (valid_vec),
        .head_payload(head_payload)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_seq_reg, out_payload_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // the head cell is only occupied while a run is being drained
    a_idle_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !valid_vec[0])
        else $error("head cell occupied while idle");

    a_run_head_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> valid_vec[0])
        else $error("release run with empty head cell");

    a_shift_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> (expected_reg == $past(expected_reg) + 16'd1))
        else $error("window shifted without advancing expected number");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (valid_vec == '0) && (expected_reg == $past(cfg_data)))
        else $error("configuration transfer did not restart the window");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !ctrl.shift && !in_fire)
        else $error("result produced while output register stalled");

endmodule

// ----- rtl/prb_cell.sv -----
// One slot of the reorder window: valid flag and parked payload.
module prb_cell
    import prb_pkg::*;
#(
    parameter int KEEP_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctrl_t       ctrl,
    input  logic              sel,
    input  logic [KEEP_W-1:0] load_data,
    input  logic              nbr_valid,
    input  logic [KEEP_W-1:0] nbr_payload,
    output logic              valid,
    output logic [KEEP_W-1:0] payload
);

    logic              valid_reg;
    logic              valid_next;
    logic [KEEP_W-1:0] payload_reg;
    logic [KEEP_W-1:0] payload_next;

    always_comb
    begin
        valid_next   = valid_reg;
        payload_next = payload_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // take over the neighbor's entry, one step closer to the head
            valid_next   = nbr_valid;
            payload_next = nbr_payload;
        end
        else if (ctrl.load && sel)
        begin
            valid_next   = 1'b1;
            payload_next = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign payload = payload_reg;

endmodule

// ----- rtl/prb_chain.sv -----
// Row of window cells; cell k holds the packet k ahead of the expected number.
module prb_chain
    import prb_pkg::*;
#(
    parameter int WINDOW = 16,
    parameter int KEEP_W = 32,
    localparam int IdxW  = $clog2(WINDOW)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctrl_t       ctrl,
    input  logic [IdxW-1:0]   load_idx,
    input  logic [KEEP_W-1:0] load_data,
    output logic [WINDOW-1:0] valid_vec,
    output logic [KEEP_W-1:0] head_payload
);

    logic [KEEP_W-1:0] payload_arr [WINDOW];
    logic [WINDOW-1:0] nbr_valid;
    logic [KEEP_W-1:0] nbr_payload [WINDOW];

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i == WINDOW - 1)
            begin : g_tail
                // the far end fills with an empty slot on each shift
                assign nbr_valid[i]   = 1'b0;
                assign nbr_payload[i] = '0;
            end
            else
            begin : g_mid
                assign nbr_valid[i]   = valid_vec[i+1];
                assign nbr_payload[i] = payload_arr[i+1];
            end

            prb_cell #(
                .KEEP_W(KEEP_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (load_idx == IdxW'(i)),
                .load_data  (load_data),
                .nbr_valid  (nbr_valid[i]),
                .nbr_payload(nbr_payload[i]),
                .valid      (valid_vec[i]),
                .payload    (payload_arr[i])
            );
        end
    endgenerate

    assign head_payload = payload_arr[0];

endmodule
